/* hdl/ple_pkg.sv */
// Shared types and constants for the positional list engine.
package ple_pkg;

  localparam int MaxResults = 16;
  localparam int ValueW = 32;
  localparam int OpW = 3;
  localparam int PosW = 8;
  localparam int StatusW = 2;
  localparam int LengthW = 5;

  typedef enum logic [OpW-1:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP      = 3'd6,
    OP_COUNT     = 3'd7
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // What every cell of the chain does in a cycle.
  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_ROT  = 2'd3
  } cell_cmd_t;

endpackage

/* hdl/ple_cell.sv */
// One storage cell of the list chain, shifting with its neighbors.
module ple_cell #(
  parameter int CAPACITY = 16,
  parameter int INDEX = 0,
  parameter int OW = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  ple_pkg::cell_cmd_t            cmd,
  input  logic [OW-1:0]                 idx,
  input  logic [OW-1:0]                 count,
  input  logic [ple_pkg::ValueW-1:0]    ins_value,
  input  logic [ple_pkg::ValueW-1:0]    left,
  input  logic [ple_pkg::ValueW-1:0]    right,
  input  logic [ple_pkg::ValueW-1:0]    front,
  output logic [ple_pkg::ValueW-1:0]    data
);

  logic [ple_pkg::ValueW-1:0] data_next;
  logic [31:0] me, at, cnt;

  assign me  = 32'(INDEX);
  assign at  = 32'(idx);
  assign cnt = 32'(count);

  always_comb begin
    data_next = data;
    case (cmd)
      ple_pkg::CMD_INS: begin
        if (me == at) begin
          data_next = ins_value;
        end else if (me > at && me <= cnt) begin
          data_next = left;
        end
      end
      ple_pkg::CMD_DEL: begin
        if (me >= at && me + 32'd1 < cnt) begin
          data_next = right;
        end
      end
      ple_pkg::CMD_ROT: begin
        // occupied cells rotate toward the front; front wraps to the back
        if (me + 32'd1 < cnt) begin
          data_next = right;
        end else if (me + 32'd1 == cnt) begin
          data_next = front;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* hdl/positional_list_engine.sv */
// Positional list engine: ordered list in a shifting chain of cells.
// Usage:
//   Input words (opcode, value, position) enter on in_valid/in_ready; result
//   words (status, element, length, last) leave on out_valid/out_ready.
//   Inserts and deletes shift the cell chain in the cycle the word is
//   accepted; the single result is registered and shows the next cycle.
//   With out_ready held high, non-dump words are taken one per cycle.
//   A dump rotates the occupied cells one place per cycle, giving the front
//   cell as a result word each cycle; when more than 16 elements are held,
//   only the first 16 are sent and the chain then rotates silently back
//   into order. No new word is accepted during a dump.
//   An empty dump gives one word with status empty. Every result carries the
//   count after the operation; only dump words carry a nonzero element.
//   When the receiver stalls the result holds in the output register and
//   in_ready drops until it is taken; a dump's sending rotations pause meanwhile.
//   Reset (rst, synchronous) empties the list and drops out_valid; cell
//   contents are not cleared.
module positional_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ple_pkg::OpW-1:0]             opcode,
  input  logic signed [ple_pkg::ValueW-1:0]   value,
  input  logic [ple_pkg::PosW-1:0]            position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ple_pkg::StatusW-1:0]         status,
  output logic signed [ple_pkg::ValueW-1:0]   element,
  output logic [ple_pkg::LengthW-1:0]         length,
  output logic                                last
);

  localparam int OW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t state, state_next;
  logic [OW-1:0] occupancy, occupancy_next;
  logic [OW-1:0] rc, rc_next;

  ple_pkg::cell_cmd_t cmd;
  logic [OW-1:0] cidx;
  logic [ple_pkg::ValueW-1:0] data_q [CAPACITY];

  logic accept, slot_free, load_out;
  logic [ple_pkg::StatusW-1:0] status_next;
  logic [ple_pkg::ValueW-1:0] element_next;
  logic last_next;

  logic [8:0] pos9, occ9;
  logic [31:0] rc32, occ32, n32;
  logic emitting;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;

  assign pos9  = 9'(position);
  assign occ9  = 9'(occupancy);
  assign rc32  = 32'(rc);
  assign occ32 = 32'(occupancy);
  assign n32   = (occ32 < 32'(ple_pkg::MaxResults)) ? occ32 : 32'(ple_pkg::MaxResults);
  assign emitting = rc32 < 32'(ple_pkg::MaxResults);

  always_comb begin
    state_next     = state;
    occupancy_next = occupancy;
    rc_next        = rc;
    cmd            = ple_pkg::CMD_HOLD;
    cidx           = '0;
    load_out       = 1'b0;
    status_next    = ple_pkg::ST_OK;
    element_next   = '0;
    last_next      = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          case (ple_pkg::op_t'(opcode))
            ple_pkg::OP_INS_FIRST, ple_pkg::OP_INS_LAST: begin
              if (occ32 >= 32'(CAPACITY)) begin
                status_next = ple_pkg::ST_FULL;
              end else begin
                cmd = ple_pkg::CMD_INS;
                cidx = (ple_pkg::op_t'(opcode) == ple_pkg::OP_INS_FIRST) ? '0 : occupancy;
                occupancy_next = occupancy + OW'(1);
              end
            end
            ple_pkg::OP_INS_AT: begin
              if (pos9 == 9'd0 || pos9 > occ9 + 9'd1) begin
                status_next = ple_pkg::ST_BADPOS;
              end else if (occ32 >= 32'(CAPACITY)) begin
                status_next = ple_pkg::ST_FULL;
              end else begin
                cmd = ple_pkg::CMD_INS;
                cidx = OW'(pos9 - 9'd1);
                occupancy_next = occupancy + OW'(1);
              end
            end
            ple_pkg::OP_DEL_FIRST, ple_pkg::OP_DEL_LAST: begin
              if (occupancy == '0) begin
                status_next = ple_pkg::ST_EMPTY;
              end else begin
                cmd = ple_pkg::CMD_DEL;
                cidx = (ple_pkg::op_t'(opcode) == ple_pkg::OP_DEL_FIRST) ? '0
                       : occupancy - OW'(1);
                occupancy_next = occupancy - OW'(1);
              end
            end
            ple_pkg::OP_DEL_AT: begin
              if (occupancy == '0) begin
                status_next = ple_pkg::ST_EMPTY;
              end else if (pos9 == 9'd0 || pos9 > occ9) begin
                status_next = ple_pkg::ST_BADPOS;
              end else begin
                cmd = ple_pkg::CMD_DEL;
                cidx = OW'(pos9 - 9'd1);
                occupancy_next = occupancy - OW'(1);
              end
            end
            ple_pkg::OP_DUMP: begin
              if (occupancy == '0) begin
                status_next = ple_pkg::ST_EMPTY;
              end else begin
                load_out = 1'b0;
                rc_next = '0;
                state_next = S_DUMP;
              end
            end
            default: begin
              status_next = ple_pkg::ST_OK;
            end
          endcase
        end
      end
      S_DUMP: begin
        // sent words wait for a free slot; silent rotations do not
        if (!emitting || slot_free) begin
          cmd = ple_pkg::CMD_ROT;
          rc_next = rc + OW'(1);
          if (emitting) begin
            load_out = 1'b1;
            element_next = data_q[0];
            last_next = (rc32 + 32'd1 == n32);
          end
          if (rc32 + 32'd1 == occ32) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      ple_cell #(
        .CAPACITY(CAPACITY),
        .INDEX(g),
        .OW(OW)
      ) u_cell (
        .clk(clk),
        .cmd(cmd),
        .idx(cidx),
        .count(occupancy),
        .ins_value(value),
        .left((g == 0) ? value : data_q[(g == 0) ? 0 : g - 1]),
        .right((g == CAPACITY - 1) ? data_q[0] : data_q[(g == CAPACITY - 1) ? 0 : g + 1]),
        .front(data_q[0]),
        .data(data_q[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      rc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
      rc        <= rc_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status  <= status_next;
      element <= element_next;
      length  <= ple_pkg::LengthW'(occupancy_next);
      last    <= last_next;
    end
  end

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the positional list engine.
module testbench;

  localparam int Capacity = 16;

  typedef struct {
    ple_pkg::status_t                    status;
    logic signed [ple_pkg::ValueW-1:0]   element;
    logic [ple_pkg::LengthW-1:0]         length;
    logic                                last;
  } result_word_t;

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_ready;
  logic [ple_pkg::OpW-1:0]             opcode;
  logic signed [ple_pkg::ValueW-1:0]   value;
  logic [ple_pkg::PosW-1:0]            position;
  logic                                out_valid;
  logic                                out_ready;
  logic [ple_pkg::StatusW-1:0]         status;
  logic signed [ple_pkg::ValueW-1:0]   element;
  logic [ple_pkg::LengthW-1:0]         length;
  logic                                last;

  logic signed [ple_pkg::ValueW-1:0] list_contents[$];
  result_word_t                      pending_results[$];
  int                                error_count;
  int                                words_sent;
  int                                words_checked;
  int                                dumps_sent;
  bit                                steady;

  positional_list_engine #(.CAPACITY(Capacity)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .value(value),
    .position(position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .element(element),
    .length(length),
    .last(last)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Receiver stalls at random unless a steady stretch is running.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 12);
  end

  task automatic push_result(ple_pkg::status_t st, logic signed [ple_pkg::ValueW-1:0] elem,
                             logic lst);
    result_word_t w;
    w.status = st;
    w.element = elem;
    w.length = ple_pkg::LengthW'(list_contents.size());
    w.last = lst;
    pending_results.push_back(w);
  endtask

  // Update the list image and queue the results one input word produces.
  task automatic update_list(ple_pkg::op_t op, logic signed [ple_pkg::ValueW-1:0] val,
                             logic [ple_pkg::PosW-1:0] pos);
    int n;
    ple_pkg::status_t st;
    n = list_contents.size();
    st = ple_pkg::ST_OK;
    case (op)
      ple_pkg::OP_INS_FIRST, ple_pkg::OP_INS_LAST: begin
        if (n >= Capacity) st = ple_pkg::ST_FULL;
        else if (op == ple_pkg::OP_INS_FIRST) list_contents.push_front(val);
        else list_contents.push_back(val);
      end
      ple_pkg::OP_INS_AT: begin
        // position is checked before fullness
        if (pos < 1 || pos > n + 1) st = ple_pkg::ST_BADPOS;
        else if (n >= Capacity) st = ple_pkg::ST_FULL;
        else list_contents.insert(pos - 1, val);
      end
      ple_pkg::OP_DEL_FIRST, ple_pkg::OP_DEL_LAST: begin
        if (n == 0) st = ple_pkg::ST_EMPTY;
        else if (op == ple_pkg::OP_DEL_FIRST) void'(list_contents.pop_front());
        else void'(list_contents.pop_back());
      end
      ple_pkg::OP_DEL_AT: begin
        // emptiness is checked before position
        if (n == 0) st = ple_pkg::ST_EMPTY;
        else if (pos < 1 || pos > n) st = ple_pkg::ST_BADPOS;
        else list_contents.delete(pos - 1);
      end
      ple_pkg::OP_DUMP: begin
        dumps_sent++;
        if (n == 0) st = ple_pkg::ST_EMPTY;
        else begin
          for (int i = 0; i < n && i < ple_pkg::MaxResults; i++)
            push_result(ple_pkg::ST_OK, list_contents[i],
                        (i + 1 == n) || (i + 1 == ple_pkg::MaxResults));
          return;
        end
      end
      default: ;
    endcase
    push_result(st, '0, 1'b1);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(ple_pkg::op_t op, logic signed [ple_pkg::ValueW-1:0] val,
                           logic [ple_pkg::PosW-1:0] pos);
    if (!steady && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    opcode <= op;
    value <= val;
    position <= pos;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    update_list(op, val, pos);
    words_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    result_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word status %0d element %0d length %0d last %0b",
                 $time, status, element, length, last);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status);
          error_count++;
        end
        if (element !== want.element) begin
          $display("%0t: element expected %0d, got %0d", $time, want.element, element);
          error_count++;
        end
        if (length !== want.length) begin
          $display("%0t: length expected %0d, got %0d", $time, want.length, length);
          error_count++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %0b, got %0b", $time, want.last, last);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_list();
    send_word(ple_pkg::OP_DEL_FIRST, '0, '0);
    send_word(ple_pkg::OP_DEL_AT, '0, 8'd1);
    send_word(ple_pkg::OP_DUMP, '0, '0);
    send_word(ple_pkg::OP_INS_AT, 32'sd5, 8'd0);
    send_word(ple_pkg::OP_INS_AT, 32'sd5, 8'd2);
    send_word(ple_pkg::OP_COUNT, '0, '0);
  endtask

  task automatic test_fill_and_overflow();
    send_word(ple_pkg::OP_INS_FIRST, 32'sh8000_0000, '0);
    send_word(ple_pkg::OP_INS_LAST, 32'sh7fff_ffff, '0);
    send_word(ple_pkg::OP_INS_AT, -32'sd1, 8'd2);
    while (list_contents.size() < Capacity)
      send_word(ple_pkg::OP_INS_LAST, $urandom, 8'hff);
    send_word(ple_pkg::OP_INS_FIRST, 32'sd1, '0);
    send_word(ple_pkg::OP_INS_AT, 32'sd2, 8'd18);
    send_word(ple_pkg::OP_INS_AT, 32'sd3, 8'd17);
    send_word(ple_pkg::OP_DUMP, '0, '0);
  endtask

  task automatic test_delete_bounds();
    send_word(ple_pkg::OP_DEL_AT, '0, 8'd0);
    send_word(ple_pkg::OP_DEL_AT, '0, 8'd255);
    send_word(ple_pkg::OP_DEL_AT, '0, 8'd16);
    send_word(ple_pkg::OP_DEL_LAST, '0, '0);
    send_word(ple_pkg::OP_DEL_FIRST, '0, '0);
    send_word(ple_pkg::OP_DUMP, '0, '0);
  endtask

  // Alternating grow and shrink phases so the list swings between empty and full.
  task automatic test_random_mix(int count);
    int n;
    int pick;
    int ins_weight;
    logic [ple_pkg::PosW-1:0] pos;
    for (int k = 0; k < count; k++) begin
      steady = (k >= 150 && k < 250);
      n = list_contents.size();
      ins_weight = ((k / 40) % 2 == 0) ? 55 : 22;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 15) pos = ple_pkg::PosW'($urandom_range(255));
      else pos = '0;
      if (pick < ins_weight) begin
        case ($urandom_range(2))
          0: send_word(ple_pkg::OP_INS_FIRST, $urandom, ple_pkg::PosW'($urandom));
          1: send_word(ple_pkg::OP_INS_LAST, $urandom, ple_pkg::PosW'($urandom));
          default: begin
            if (pos == '0) pos = ple_pkg::PosW'($urandom_range(n + 1, 1));
            send_word(ple_pkg::OP_INS_AT, $urandom, pos);
          end
        endcase
      end else if (pick < 85) begin
        case ($urandom_range(2))
          0: send_word(ple_pkg::OP_DEL_FIRST, $urandom, ple_pkg::PosW'($urandom));
          1: send_word(ple_pkg::OP_DEL_LAST, $urandom, ple_pkg::PosW'($urandom));
          default: begin
            if (pos == '0 && n > 0) pos = ple_pkg::PosW'($urandom_range(n, 1));
            send_word(ple_pkg::OP_DEL_AT, $urandom, pos);
          end
        endcase
      end else if (pick < 95) begin
        send_word(ple_pkg::OP_DUMP, $urandom, ple_pkg::PosW'($urandom));
      end else begin
        send_word(ple_pkg::OP_COUNT, $urandom, ple_pkg::PosW'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = ple_pkg::OP_COUNT;
    value = '0;
    position = '0;
    steady = 1'b0;
    error_count = 0;
    words_sent = 0;
    words_checked = 0;
    dumps_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_fill_and_overflow();
    test_delete_bounds();
    test_random_mix(410);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d input words (%0d dumps), checked %0d result words.",
             words_sent, dumps_sent, words_checked);
    $display("Covered empty, full and bad-position cases plus a random insert/delete mix.");
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
